@@ hw/rtl/cba_pkg.sv @@
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes of the chained block allocator: request codes,
// status codes, image states and the sequencer state types.
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int FUNC_W    = 4;
   localparam int SESSION_W = 63;
   localparam int IMG_IDX_W = 10;
   localparam int PIX_W     = 13;
   localparam int COUNT_W   = 13;
   localparam int BLK_IDX_W = 12;
   localparam int STATUS_W  = 3;
   localparam int ISTATE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int BCOUNT_W  = 13;
   localparam int ICOUNT_W  = 11;

   localparam logic [FUNC_W-1:0] FN_CLEAR = 4'd0;
   localparam logic [FUNC_W-1:0] FN_CHECK = 4'd1;
   localparam logic [FUNC_W-1:0] FN_NONE  = 4'd2;
   localparam logic [FUNC_W-1:0] FN_ANY   = 4'd3;
   localparam logic [FUNC_W-1:0] FN_SIZE  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_ROOM  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_STORE = 4'd6;
   localparam logic [FUNC_W-1:0] FN_LOOK  = 4'd7;
   localparam logic [FUNC_W-1:0] FN_NEXT  = 4'd8;
   localparam logic [FUNC_W-1:0] FN_FREE  = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SESSION = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NREADY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd5;

   localparam logic [ISTATE_W-1:0] IS_EMPTY  = 2'd0;
   localparam logic [ISTATE_W-1:0] IS_STORED = 2'd1;
   localparam logic [ISTATE_W-1:0] IS_NONE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SESSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READY   = 2'd3;

   typedef enum logic [4:0] {
      S_SWEEP,
      S_IDLE,
      S_CHECK,
      S_SIZE,
      S_IMG_RD,
      S_IMG_EV,
      S_WALK_RD,
      S_WALK_EV,
      S_WALK_END,
      S_SCAN_RD,
      S_SCAN_EV,
      S_TAIL,
      S_ROOM_PICK,
      S_ROOM_RD,
      S_ROOM_EV,
      S_NEXT_RD,
      S_NEXT_EV,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      SZ_IDLE,
      SZ_LINES,
      SZ_COUNT
   } sizer_state_type;

   typedef enum logic {
      PH_COUNT,
      PH_ALLOC
   } phase_type;

endpackage

@@ hw/rtl/cba_ram.sv @@
// ----------------------------------------------------------------------------
// cba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cba_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 13
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/cba_sizer.sv @@
// ----------------------------------------------------------------------------
// cba_sizer
// Blocks needed for an image: lines per block, then a rounded-up division of
// the height, both on one bit-serial restoring divider. Zero on a bad width.
// ----------------------------------------------------------------------------
module cba_sizer #(
   parameter int BLOCK_BYTES = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cba_pkg::PIX_W-1:0]   width,
   input  logic [cba_pkg::PIX_W-1:0]   height,
   output logic                        done,
   output logic [cba_pkg::COUNT_W-1:0] blocks
);

   localparam int DW  = $clog2(BLOCK_BYTES + 8192);
   localparam int CNW = $clog2(DW);
   localparam int NW  = cba_pkg::COUNT_W;

   cba_pkg::sizer_state_type st_ff, st_in;
   logic [DW-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [NW-1:0]  blocks_ff, blocks_in;
   logic [DW:0]    trial;
   logic           fits;
   logic [DW-1:0]  rem_next, quo_next;
   logic           last;

   always_comb begin
      trial    = {rem_ff, quo_ff[DW-1]};
      fits     = trial >= {1'b0, dvs_ff};
      rem_next = fits ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
      quo_next = {quo_ff[DW-2:0], fits};
      last     = cnt_ff == CNW'(DW - 1);
   end

   always_comb begin
      st_in     = st_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      blocks_in = blocks_ff;
      unique case (st_ff)
         cba_pkg::SZ_IDLE: begin
            if (start) begin
               if (width == '0 || 32'(width) > BLOCK_BYTES / 2) begin
                  done_in   = 1'b1;
                  blocks_in = '0;
               end else begin
                  quo_in = DW'(BLOCK_BYTES);
                  dvs_in = DW'({width, 1'b0});
                  rem_in = '0;
                  cnt_in = '0;
                  st_in  = cba_pkg::SZ_LINES;
               end
            end
         end
         cba_pkg::SZ_LINES: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff + CNW'(1);
            if (last) begin
               quo_in = DW'(height) + quo_next - DW'(1);
               dvs_in = quo_next;
               rem_in = '0;
               cnt_in = '0;
               st_in  = cba_pkg::SZ_COUNT;
            end
         end
         cba_pkg::SZ_COUNT: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff + CNW'(1);
            if (last) begin
               blocks_in = (quo_next == '0) ? NW'(1) : NW'(quo_next);
               done_in   = 1'b1;
               st_in     = cba_pkg::SZ_IDLE;
            end
         end
         default: st_in = cba_pkg::SZ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= cba_pkg::SZ_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      cnt_ff    <= cnt_in;
      blocks_ff <= blocks_in;
   end

   assign done   = done_ff;
   assign blocks = blocks_ff;

endmodule

@@ hw/rtl/chained_block_allocator.sv @@
// ----------------------------------------------------------------------------
// chained_block_allocator
// Chained block allocation table with an image table of first block, width
// and height; clear, check, mark none, any empty, size, make room, store,
// lookup, next and free requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on the rsp_ ports for a single cycle with rsp_strobe, and the
// receiver cannot hold it off. The work depends on the request: check,
// lookup and next need only a table read; size runs the bit-serial divider;
// any empty scans the image slots until it finds an empty one; free, mark
// none and make room walk chain blocks; a store adds two scans of the link
// table and two walks of the old chain. All table accesses go through
// simple dual-port RAMs with one write and one registered read port. After
// reset, and for every clear request, a clearing pass over
// max(MAX_BLOCKS, MAX_IMAGES) table entries runs with busy high;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module chained_block_allocator #(
   parameter int MAX_BLOCKS  = 4096,
   parameter int MAX_IMAGES  = 1024,
   parameter int BLOCK_BYTES = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cba_pkg::FUNC_W-1:0]     req_func,
   input  logic [cba_pkg::SESSION_W-1:0]  req_session_id,
   input  logic [cba_pkg::IMG_IDX_W-1:0]  req_image_index,
   input  logic [cba_pkg::PIX_W-1:0]      req_pixel_width,
   input  logic [cba_pkg::PIX_W-1:0]      req_pixel_height,
   input  logic [cba_pkg::COUNT_W-1:0]    req_blocks_wanted,
   input  logic [cba_pkg::BLK_IDX_W-1:0]  req_block_index,
   output logic                           rsp_strobe,
   output logic [cba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cba_pkg::ISTATE_W-1:0]   rsp_image_state,
   output logic [cba_pkg::BLK_IDX_W-1:0]  rsp_first_block,
   output logic [cba_pkg::PIX_W-1:0]      rsp_stored_width,
   output logic [cba_pkg::PIX_W-1:0]      rsp_stored_height,
   output logic [cba_pkg::COUNT_W-1:0]    rsp_blocks_needed,
   output logic [cba_pkg::BLK_IDX_W-1:0]  rsp_next_block,
   output logic                           rsp_chain_end,
   output logic [cba_pkg::COUNT_W-1:0]    rsp_free_blocks,
   output logic                           rsp_any_empty,
   input  logic                           csr_write,
   input  logic [cba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cba_pkg::SESSION_W-1:0]  csr_data
);

   localparam int LW   = $clog2(MAX_BLOCKS + 2);
   localparam int BAW  = $clog2(MAX_BLOCKS);
   localparam int IAW  = $clog2(MAX_IMAGES);
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int ICW  = $clog2(MAX_IMAGES + 1);
   localparam int SCW  = (CW > ICW) ? CW : ICW;
   localparam int RW   = ICW + 1;
   localparam int NW   = cba_pkg::COUNT_W;
   localparam int PW   = cba_pkg::PIX_W;
   localparam int FBW  = cba_pkg::BLK_IDX_W;
   localparam int XW   = cba_pkg::IMG_IDX_W;
   localparam int KW   = (CW > NW) ? CW : NW;
   localparam int BXW  = (CW > FBW) ? CW : FBW;
   localparam int IXW  = (ICW > XW) ? ICW : XW;
   localparam int BCW  = (CW > cba_pkg::BCOUNT_W) ? CW : cba_pkg::BCOUNT_W;
   localparam int ICRW = (ICW > cba_pkg::ICOUNT_W) ? ICW : cba_pkg::ICOUNT_W;
   localparam int SWN  = (MAX_BLOCKS > MAX_IMAGES) ? MAX_BLOCKS : MAX_IMAGES;
   localparam int SWW  = $clog2(SWN);
   localparam int WHW  = 2 * PW;

   localparam logic [LW-1:0] LINK_END  = LW'(MAX_BLOCKS);
   localparam logic [LW-1:0] LINK_FREE = LW'(MAX_BLOCKS + 1);
   localparam logic [LW-1:0] IMG_EMPTY = LW'(MAX_BLOCKS);
   localparam logic [LW-1:0] IMG_NONE  = LW'(MAX_BLOCKS + 1);

   function automatic logic [cba_pkg::ISTATE_W-1:0] state_of(input logic [LW-1:0] f);
      logic [cba_pkg::ISTATE_W-1:0] s;
      if (f == IMG_EMPTY) s = cba_pkg::IS_EMPTY;
      else if (f == IMG_NONE) s = cba_pkg::IS_NONE;
      else s = cba_pkg::IS_STORED;
      return s;
   endfunction

   // configuration
   logic [cba_pkg::SESSION_W-1:0] session_ff;
   logic [cba_pkg::BCOUNT_W-1:0]  block_count_ff;
   logic [cba_pkg::ICOUNT_W-1:0]  image_count_ff;
   logic                          ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff     <= '0;
         block_count_ff <= '0;
         image_count_ff <= '0;
         ready_ff       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            cba_pkg::CSR_SESSION: session_ff     <= csr_data;
            cba_pkg::CSR_BLOCKS:  block_count_ff <= csr_data[cba_pkg::BCOUNT_W-1:0];
            cba_pkg::CSR_IMAGES:  image_count_ff <= csr_data[cba_pkg::ICOUNT_W-1:0];
            cba_pkg::CSR_READY:   ready_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0]  nblk;
   logic [ICW-1:0] nimg;

   assign nblk = (BCW'(block_count_ff) > BCW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                           : CW'(block_count_ff);
   assign nimg = (ICRW'(image_count_ff) > ICRW'(MAX_IMAGES)) ? ICW'(MAX_IMAGES)
                                                             : ICW'(image_count_ff);

   // sequencer registers
   cba_pkg::state_type state_ff, state_in;
   cba_pkg::phase_type phase_ff, phase_in;
   logic                   op_ff, op_in;
   logic [SWW-1:0]         sweep_ff, sweep_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [cba_pkg::FUNC_W-1:0] func_ff, func_in;
   logic                   sess_ok_ff, sess_ok_in;
   logic [XW-1:0]          idx_ff, idx_in;
   logic [PW-1:0]          w_ff, w_in, h_ff, h_in;
   logic [NW-1:0]          want_ff, want_in;
   logic [FBW-1:0]         bix_ff, bix_in;
   logic [NW-1:0]          nb_ff, nb_in;
   logic [LW-1:0]          first_ff, first_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [CW-1:0]          steps_ff, steps_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   walk_free_ff, walk_free_in;
   logic [SCW-1:0]         scan_ff, scan_in;
   logic [BAW-1:0]         prev_ff, prev_in;
   logic [BAW-1:0]         fblk_ff, fblk_in;
   logic [NW-1:0]          acnt_ff, acnt_in;
   logic [RW-1:0]          st_ff, st_in, ed1_ff, ed1_in;
   logic [IAW-1:0]         cr_ff, cr_in;

   // result registers
   logic [cba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [cba_pkg::ISTATE_W-1:0] istate_ff, istate_in;
   logic [FBW-1:0]         fout_ff, fout_in;
   logic [PW-1:0]          wout_ff, wout_in, hout_ff, hout_in;
   logic [NW-1:0]          nbout_ff, nbout_in;
   logic [FBW-1:0]         nxout_ff, nxout_in;
   logic                   cend_ff, cend_in;
   logic                   any_ff, any_in;
   logic                   fin_ff, fin_in;

   // memory ports
   logic           lk_we, lk_re, fi_we, fi_re, wh_we, wh_re;
   logic [BAW-1:0] lk_waddr, lk_raddr;
   logic [LW-1:0]  lk_wdata, lk_rdata;
   logic [IAW-1:0] fi_waddr, fi_raddr, wh_waddr, wh_raddr;
   logic [LW-1:0]  fi_wdata, fi_rdata;
   logic [WHW-1:0] wh_wdata, wh_rdata;

   logic           sz_start, sz_done;
   logic [NW-1:0]  sz_blocks;

   logic [CW-1:0]  free_cnt;
   logic [RW-1:0]  ix_r, ed_m1;
   logic           room_go, pick_low;
   logic [SCW-1:0] scan_lim;
   logic           is_last_sweep;

   assign free_cnt      = (nblk > used_ff) ? nblk - used_ff : '0;
   assign ix_r          = RW'(idx_ff);
   assign ed_m1         = ed1_ff - RW'(1);
   assign room_go       = (st_ff <= ix_r) && (ed1_ff > ix_r);
   assign pick_low      = (ix_r - st_ff) > (ed_m1 - ix_r);
   assign scan_lim      = (func_ff == cba_pkg::FN_ANY) ? SCW'(nimg) : SCW'(nblk);
   assign is_last_sweep = sweep_ff == SWW'(SWN - 1);

   cba_ram #(.DEPTH(MAX_BLOCKS), .AW(BAW), .DW(LW)) u_link_ram (
      .clock (clock),
      .we    (lk_we),
      .waddr (lk_waddr),
      .wdata (lk_wdata),
      .re    (lk_re),
      .raddr (lk_raddr),
      .rdata (lk_rdata)
   );

   cba_ram #(.DEPTH(MAX_IMAGES), .AW(IAW), .DW(LW)) u_first_ram (
      .clock (clock),
      .we    (fi_we),
      .waddr (fi_waddr),
      .wdata (fi_wdata),
      .re    (fi_re),
      .raddr (fi_raddr),
      .rdata (fi_rdata)
   );

   cba_ram #(.DEPTH(MAX_IMAGES), .AW(IAW), .DW(WHW)) u_size_ram (
      .clock (clock),
      .we    (wh_we),
      .waddr (wh_waddr),
      .wdata (wh_wdata),
      .re    (wh_re),
      .raddr (wh_raddr),
      .rdata (wh_rdata)
   );

   cba_sizer #(.BLOCK_BYTES(BLOCK_BYTES)) u_sizer (
      .clock  (clock),
      .reset  (reset),
      .start  (sz_start),
      .width  (w_ff),
      .height (h_ff),
      .done   (sz_done),
      .blocks (sz_blocks)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      sweep_in     = sweep_ff;
      used_in      = used_ff;
      func_in      = func_ff;
      sess_ok_in   = sess_ok_ff;
      idx_in       = idx_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      want_in      = want_ff;
      bix_in       = bix_ff;
      nb_in        = nb_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      cnt_in       = cnt_ff;
      walk_free_in = walk_free_ff;
      scan_in      = scan_ff;
      prev_in      = prev_ff;
      fblk_in      = fblk_ff;
      acnt_in      = acnt_ff;
      st_in        = st_ff;
      ed1_in       = ed1_ff;
      cr_in        = cr_ff;
      status_in    = status_ff;
      istate_in    = istate_ff;
      fout_in      = fout_ff;
      wout_in      = wout_ff;
      hout_in      = hout_ff;
      nbout_in     = nbout_ff;
      nxout_in     = nxout_ff;
      cend_in      = cend_ff;
      any_in       = any_ff;
      fin_in       = fin_ff;

      lk_we    = 1'b0;
      lk_waddr = cur_ff[BAW-1:0];
      lk_wdata = LINK_FREE;
      lk_re    = 1'b0;
      lk_raddr = cur_ff[BAW-1:0];
      fi_we    = 1'b0;
      fi_waddr = IAW'(idx_ff);
      fi_wdata = IMG_EMPTY;
      fi_re    = 1'b0;
      fi_raddr = IAW'(idx_ff);
      wh_we    = 1'b0;
      wh_waddr = IAW'(idx_ff);
      wh_wdata = {w_ff, h_ff};
      wh_re    = 1'b0;
      wh_raddr = IAW'(idx_ff);
      sz_start = 1'b0;

      unique case (state_ff)
         cba_pkg::S_SWEEP: begin
            lk_we    = 32'(sweep_ff) < MAX_BLOCKS;
            lk_waddr = sweep_ff[BAW-1:0];
            lk_wdata = LINK_FREE;
            fi_we    = 32'(sweep_ff) < MAX_IMAGES;
            fi_waddr = sweep_ff[IAW-1:0];
            fi_wdata = IMG_EMPTY;
            used_in  = '0;
            sweep_in = sweep_ff + SWW'(1);
            if (is_last_sweep) begin
               sweep_in = '0;
               state_in = op_ff ? cba_pkg::S_RESP : cba_pkg::S_IDLE;
            end
         end
         cba_pkg::S_IDLE: begin
            if (start) begin
               func_in    = req_func;
               sess_ok_in = req_session_id == session_ff;
               idx_in     = req_image_index;
               w_in       = req_pixel_width;
               h_in       = req_pixel_height;
               want_in    = req_blocks_wanted;
               bix_in     = req_block_index;
               status_in  = cba_pkg::ST_OK;
               istate_in  = cba_pkg::IS_EMPTY;
               fout_in    = '0;
               wout_in    = '0;
               hout_in    = '0;
               nbout_in   = '0;
               nxout_in   = '0;
               cend_in    = 1'b0;
               any_in     = 1'b0;
               fin_in     = 1'b0;
               op_in      = 1'b1;
               state_in   = cba_pkg::S_CHECK;
            end
         end
         cba_pkg::S_CHECK: begin
            if (func_ff > cba_pkg::FN_FREE) begin
               state_in = cba_pkg::S_RESP;
            end else if (!sess_ok_ff) begin
               status_in = cba_pkg::ST_SESSION;
               state_in  = cba_pkg::S_RESP;
            end else if (!ready_ff) begin
               status_in = cba_pkg::ST_NREADY;
               state_in  = cba_pkg::S_RESP;
            end else begin
               fin_in = 1'b1;
               if ((func_ff == cba_pkg::FN_CHECK || func_ff == cba_pkg::FN_NONE ||
                    func_ff == cba_pkg::FN_ROOM || func_ff == cba_pkg::FN_STORE ||
                    func_ff == cba_pkg::FN_LOOK || func_ff == cba_pkg::FN_FREE) &&
                   IXW'(idx_ff) >= IXW'(nimg)) begin
                  status_in = cba_pkg::ST_RANGE;
                  state_in  = cba_pkg::S_RESP;
               end else begin
                  unique case (func_ff)
                     cba_pkg::FN_CLEAR: begin
                        sweep_in = '0;
                        state_in = cba_pkg::S_SWEEP;
                     end
                     cba_pkg::FN_CHECK, cba_pkg::FN_NONE, cba_pkg::FN_LOOK,
                     cba_pkg::FN_FREE: begin
                        state_in = cba_pkg::S_IMG_RD;
                     end
                     cba_pkg::FN_ANY: begin
                        scan_in  = '0;
                        state_in = cba_pkg::S_SCAN_RD;
                     end
                     cba_pkg::FN_SIZE, cba_pkg::FN_STORE: begin
                        sz_start = 1'b1;
                        state_in = cba_pkg::S_SIZE;
                     end
                     cba_pkg::FN_ROOM: begin
                        st_in     = '0;
                        ed1_in    = RW'(nimg);
                        status_in = cba_pkg::ST_SHORT;
                        state_in  = cba_pkg::S_ROOM_PICK;
                     end
                     cba_pkg::FN_NEXT: begin
                        if (BXW'(bix_ff) >= BXW'(nblk)) begin
                           status_in = cba_pkg::ST_RANGE;
                           state_in  = cba_pkg::S_RESP;
                        end else begin
                           state_in = cba_pkg::S_NEXT_RD;
                        end
                     end
                     default: state_in = cba_pkg::S_RESP;
                  endcase
               end
            end
         end
         cba_pkg::S_SIZE: begin
            if (sz_done) begin
               nb_in = sz_blocks;
               if (sz_blocks == '0) begin
                  status_in = cba_pkg::ST_BAD;
               end else begin
                  nbout_in = sz_blocks;
               end
               if (func_ff == cba_pkg::FN_STORE) begin
                  state_in = cba_pkg::S_IMG_RD;
               end else begin
                  if (sz_blocks != '0 && KW'(free_cnt) < KW'(sz_blocks)) begin
                     status_in = cba_pkg::ST_SHORT;
                  end
                  state_in = cba_pkg::S_RESP;
               end
            end
         end
         cba_pkg::S_IMG_RD: begin
            fi_re    = 1'b1;
            wh_re    = 1'b1;
            state_in = cba_pkg::S_IMG_EV;
         end
         cba_pkg::S_IMG_EV: begin
            first_in  = fi_rdata;
            istate_in = state_of(fi_rdata);
            state_in  = cba_pkg::S_RESP;
            case (func_ff)
               cba_pkg::FN_NONE, cba_pkg::FN_FREE: begin
                  cur_in       = fi_rdata;
                  steps_in     = '0;
                  walk_free_in = 1'b1;
                  state_in     = cba_pkg::S_WALK_RD;
               end
               cba_pkg::FN_STORE: begin
                  if (nb_ff != '0) begin
                     scan_in  = '0;
                     cnt_in   = '0;
                     phase_in = cba_pkg::PH_COUNT;
                     state_in = cba_pkg::S_SCAN_RD;
                  end
               end
               cba_pkg::FN_LOOK: begin
                  if (fi_rdata < LINK_END) begin
                     fout_in = FBW'(fi_rdata[BAW-1:0]);
                     wout_in = wh_rdata[WHW-1:PW];
                     hout_in = wh_rdata[PW-1:0];
                  end else begin
                     status_in = cba_pkg::ST_BAD;
                  end
               end
               default: ;
            endcase
         end
         cba_pkg::S_WALK_RD: begin
            if (cur_ff < LINK_END && 32'(steps_ff) < MAX_BLOCKS) begin
               lk_re    = 1'b1;
               state_in = cba_pkg::S_WALK_EV;
            end else begin
               state_in = cba_pkg::S_WALK_END;
            end
         end
         cba_pkg::S_WALK_EV: begin
            if (lk_rdata == LINK_FREE) begin
               state_in = cba_pkg::S_WALK_END;
            end else begin
               if (walk_free_ff) begin
                  lk_we = 1'b1;
                  if (used_ff != '0) used_in = used_ff - CW'(1);
               end else if (CW'(cur_ff) < nblk) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               cur_in   = lk_rdata;
               steps_in = steps_ff + CW'(1);
               state_in = cba_pkg::S_WALK_RD;
            end
         end
         cba_pkg::S_WALK_END: begin
            state_in = cba_pkg::S_RESP;
            case (func_ff)
               cba_pkg::FN_NONE: begin
                  fi_we     = 1'b1;
                  fi_wdata  = IMG_NONE;
                  istate_in = cba_pkg::IS_NONE;
               end
               cba_pkg::FN_FREE: begin
                  fi_we     = 1'b1;
                  istate_in = cba_pkg::IS_EMPTY;
               end
               cba_pkg::FN_ROOM: begin
                  fi_we    = 1'b1;
                  fi_waddr = cr_ff;
                  if (KW'(free_cnt) >= KW'(want_ff)) begin
                     status_in = cba_pkg::ST_OK;
                     state_in  = cba_pkg::S_IMG_RD;
                  end else begin
                     state_in = cba_pkg::S_ROOM_PICK;
                  end
               end
               cba_pkg::FN_STORE: begin
                  if (!walk_free_ff) begin
                     if (KW'(cnt_ff) < KW'(nb_ff)) begin
                        status_in = cba_pkg::ST_SHORT;
                        istate_in = state_of(first_ff);
                     end else begin
                        walk_free_in = 1'b1;
                        cur_in       = first_ff;
                        steps_in     = '0;
                        state_in     = cba_pkg::S_WALK_RD;
                     end
                  end else begin
                     wh_we    = 1'b1;
                     phase_in = cba_pkg::PH_ALLOC;
                     scan_in  = '0;
                     acnt_in  = '0;
                     state_in = cba_pkg::S_SCAN_RD;
                  end
               end
               default: ;
            endcase
         end
         cba_pkg::S_SCAN_RD: begin
            lk_raddr = scan_ff[BAW-1:0];
            fi_raddr = scan_ff[IAW-1:0];
            if (scan_ff < scan_lim &&
                !(phase_ff == cba_pkg::PH_ALLOC && acnt_ff == nb_ff &&
                  func_ff == cba_pkg::FN_STORE)) begin
               if (func_ff == cba_pkg::FN_ANY) fi_re = 1'b1;
               else lk_re = 1'b1;
               state_in = cba_pkg::S_SCAN_EV;
            end else if (func_ff == cba_pkg::FN_ANY) begin
               state_in = cba_pkg::S_RESP;
            end else if (phase_ff == cba_pkg::PH_COUNT) begin
               cur_in       = first_ff;
               steps_in     = '0;
               walk_free_in = 1'b0;
               state_in     = cba_pkg::S_WALK_RD;
            end else begin
               state_in = cba_pkg::S_TAIL;
            end
         end
         cba_pkg::S_SCAN_EV: begin
            scan_in  = scan_ff + SCW'(1);
            state_in = cba_pkg::S_SCAN_RD;
            if (func_ff == cba_pkg::FN_ANY) begin
               if (fi_rdata == IMG_EMPTY) begin
                  any_in   = 1'b1;
                  state_in = cba_pkg::S_RESP;
               end
            end else if (lk_rdata == LINK_FREE) begin
               if (phase_ff == cba_pkg::PH_COUNT) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  if (acnt_ff == '0) begin
                     fblk_in = scan_ff[BAW-1:0];
                  end else begin
                     lk_we    = 1'b1;
                     lk_waddr = prev_ff;
                     lk_wdata = LW'(scan_ff[BAW-1:0]);
                  end
                  prev_in = scan_ff[BAW-1:0];
                  acnt_in = acnt_ff + NW'(1);
                  used_in = used_ff + CW'(1);
               end
            end
         end
         cba_pkg::S_TAIL: begin
            lk_we     = 1'b1;
            lk_waddr  = prev_ff;
            lk_wdata  = LINK_END;
            fi_we     = 1'b1;
            fi_wdata  = LW'(fblk_ff);
            istate_in = cba_pkg::IS_STORED;
            fout_in   = FBW'(fblk_ff);
            wout_in   = w_ff;
            hout_in   = h_ff;
            state_in  = cba_pkg::S_RESP;
         end
         cba_pkg::S_ROOM_PICK: begin
            if (room_go) begin
               if (pick_low) begin
                  cr_in = st_ff[IAW-1:0];
                  st_in = st_ff + RW'(1);
               end else begin
                  cr_in  = ed_m1[IAW-1:0];
                  ed1_in = ed_m1;
               end
               state_in = cba_pkg::S_ROOM_RD;
            end else begin
               state_in = cba_pkg::S_IMG_RD;
            end
         end
         cba_pkg::S_ROOM_RD: begin
            fi_re    = 1'b1;
            fi_raddr = cr_ff;
            state_in = cba_pkg::S_ROOM_EV;
         end
         cba_pkg::S_ROOM_EV: begin
            if (fi_rdata < LINK_END) begin
               cur_in       = fi_rdata;
               steps_in     = '0;
               walk_free_in = 1'b1;
               state_in     = cba_pkg::S_WALK_RD;
            end else if (KW'(free_cnt) >= KW'(want_ff)) begin
               status_in = cba_pkg::ST_OK;
               state_in  = cba_pkg::S_IMG_RD;
            end else begin
               state_in = cba_pkg::S_ROOM_PICK;
            end
         end
         cba_pkg::S_NEXT_RD: begin
            lk_re    = 1'b1;
            lk_raddr = BAW'(bix_ff);
            state_in = cba_pkg::S_NEXT_EV;
         end
         cba_pkg::S_NEXT_EV: begin
            if (lk_rdata == LINK_FREE) status_in = cba_pkg::ST_BAD;
            else if (lk_rdata >= LINK_END) cend_in = 1'b1;
            else nxout_in = FBW'(lk_rdata[BAW-1:0]);
            state_in = cba_pkg::S_RESP;
         end
         cba_pkg::S_RESP: begin
            op_in    = 1'b0;
            state_in = cba_pkg::S_IDLE;
         end
         default: state_in = cba_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::S_SWEEP;
         op_ff    <= 1'b0;
         sweep_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         sweep_ff <= sweep_in;
         used_ff  <= used_in;
      end
      phase_ff     <= phase_in;
      func_ff      <= func_in;
      sess_ok_ff   <= sess_ok_in;
      idx_ff       <= idx_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      want_ff      <= want_in;
      bix_ff       <= bix_in;
      nb_ff        <= nb_in;
      first_ff     <= first_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      cnt_ff       <= cnt_in;
      walk_free_ff <= walk_free_in;
      scan_ff      <= scan_in;
      prev_ff      <= prev_in;
      fblk_ff      <= fblk_in;
      acnt_ff      <= acnt_in;
      st_ff        <= st_in;
      ed1_ff       <= ed1_in;
      cr_ff        <= cr_in;
      status_ff    <= status_in;
      istate_ff    <= istate_in;
      fout_ff      <= fout_in;
      wout_ff      <= wout_in;
      hout_ff      <= hout_in;
      nbout_ff     <= nbout_in;
      nxout_ff     <= nxout_in;
      cend_ff      <= cend_in;
      any_ff       <= any_in;
      fin_ff       <= fin_in;
   end

   assign busy              = state_ff != cba_pkg::S_IDLE;
   assign rsp_strobe        = state_ff == cba_pkg::S_RESP;
   assign rsp_status        = status_ff;
   assign rsp_image_state   = istate_ff;
   assign rsp_first_block   = fout_ff;
   assign rsp_stored_width  = wout_ff;
   assign rsp_stored_height = hout_ff;
   assign rsp_blocks_needed = nbout_ff;
   assign rsp_next_block    = nxout_ff;
   assign rsp_chain_end     = cend_ff;
   assign rsp_free_blocks   = fin_ff ? NW'(free_cnt) : '0;
   assign rsp_any_empty     = any_ff;

endmodule

@@ dv/chained_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// chained_block_allocator_tb
// Self-checking bench for the chained block allocator. A directed table covers
// session and range errors, bad widths, short stores, chain walks and
// eviction. Random requests then run under several table sizes, one with ready
// off. Each result is checked against a fixed expected value or an in-bench
// model of the link and image tables.
module chained_block_allocator_tb;
   import cba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBLK     = 4096;
   localparam int NIMG     = 1024;
   localparam int BBYTES   = 8192;
   localparam int LNK_END  = NBLK;
   localparam int LNK_FREE = NBLK + 1;
   localparam int IMG_EMP  = NBLK;
   localparam int IMG_NON  = NBLK + 1;

   typedef struct {
      logic [FUNC_W-1:0]    func;
      logic [SESSION_W-1:0] session_id;
      logic [IMG_IDX_W-1:0] image_index;
      logic [PIX_W-1:0]     pixel_width;
      logic [PIX_W-1:0]     pixel_height;
      logic [COUNT_W-1:0]   blocks_wanted;
      logic [BLK_IDX_W-1:0] block_index;
   } req_t;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ISTATE_W-1:0]  image_state;
      logic [BLK_IDX_W-1:0] first_block;
      logic [PIX_W-1:0]     stored_width;
      logic [PIX_W-1:0]     stored_height;
      logic [COUNT_W-1:0]   blocks_needed;
      logic [BLK_IDX_W-1:0] next_block;
      logic                 chain_end;
      logic [COUNT_W-1:0]   free_blocks;
      logic                 any_empty;
   } rsp_t;

   typedef struct {
      req_t r;
      bit   typed;
      rsp_t exp;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [SESSION_W-1:0] req_session_id = '0;
   logic [IMG_IDX_W-1:0] req_image_index = '0;
   logic [PIX_W-1:0]     req_pixel_width = '0;
   logic [PIX_W-1:0]     req_pixel_height = '0;
   logic [COUNT_W-1:0]   req_blocks_wanted = '0;
   logic [BLK_IDX_W-1:0] req_block_index = '0;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ISTATE_W-1:0]  rsp_image_state;
   logic [BLK_IDX_W-1:0] rsp_first_block;
   logic [PIX_W-1:0]     rsp_stored_width;
   logic [PIX_W-1:0]     rsp_stored_height;
   logic [COUNT_W-1:0]   rsp_blocks_needed;
   logic [BLK_IDX_W-1:0] rsp_next_block;
   logic                 rsp_chain_end;
   logic [COUNT_W-1:0]   rsp_free_blocks;
   logic                 rsp_any_empty;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SESSION_W-1:0] csr_data = '0;

   chained_block_allocator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // allocator model state
   int unsigned links [NBLK];
   int unsigned img_first [NIMG];
   int unsigned img_w [NIMG];
   int unsigned img_h [NIMG];
   int unsigned used_cnt;
   logic [SESSION_W-1:0] cur_session;
   int unsigned blk_reg, img_reg, ready_reg;

   rsp_t pending_rsp [$];
   int   mismatches = 0;
   int   gap_pct = 0;
   row_t dir_rows [$];

   function automatic int unsigned live_blocks();
      return (blk_reg > NBLK) ? NBLK : blk_reg;
   endfunction

   function automatic int unsigned live_images();
      return (img_reg > NIMG) ? NIMG : img_reg;
   endfunction

   function automatic int unsigned blocks_free();
      int unsigned n;
      n = live_blocks();
      return (n > used_cnt) ? n - used_cnt : 0;
   endfunction

   function automatic void wipe_tables();
      foreach (links[i]) links[i] = LNK_FREE;
      foreach (img_first[i]) img_first[i] = IMG_EMP;
      used_cnt = 0;
   endfunction

   function automatic int unsigned blocks_for(int unsigned w, int unsigned h);
      int unsigned lines, b;
      if (w == 0 || w > BBYTES / 2) return 0;
      lines = BBYTES / (2 * w);
      b = (h + lines - 1) / lines;
      return (b == 0) ? 1 : b;
   endfunction

   function automatic logic [ISTATE_W-1:0] slot_state(int unsigned ix);
      if (img_first[ix] == IMG_EMP) return IS_EMPTY;
      if (img_first[ix] == IMG_NON) return IS_NONE;
      return IS_STORED;
   endfunction

   function automatic void release_chain(int unsigned ix);
      int unsigned b, steps, nx;
      b = img_first[ix];
      steps = 0;
      img_first[ix] = IMG_EMP;
      while (b < NBLK && steps < NBLK) begin
         nx = links[b];
         if (nx == LNK_FREE) break;
         links[b] = LNK_FREE;
         if (used_cnt > 0) used_cnt--;
         b = nx;
         steps++;
      end
   endfunction

   function automatic int unsigned owned_in_range(int unsigned ix, int unsigned nb);
      int unsigned b, steps, n, nx;
      b = img_first[ix];
      steps = 0;
      n = 0;
      while (b < NBLK && steps < NBLK) begin
         nx = links[b];
         if (nx == LNK_FREE) break;
         if (b < nb) n++;
         b = nx;
         steps++;
      end
      return n;
   endfunction

   function automatic rsp_t allocate_reply(req_t q);
      rsp_t e;
      int unsigned ix, nb, ni, need, avail, cnt, prev, head;
      int st, ed, cr;
      e = '0;
      ix = q.image_index;
      nb = live_blocks();
      ni = live_images();
      if (q.func > FN_FREE) return e;
      if (q.session_id != cur_session) begin
         e.status = ST_SESSION;
         return e;
      end
      if (ready_reg == 0) begin
         e.status = ST_NREADY;
         return e;
      end
      if (q.func inside {FN_CHECK, FN_NONE, FN_ROOM, FN_STORE, FN_LOOK, FN_FREE}
          && ix >= ni) begin
         e.status = ST_RANGE;
         e.free_blocks = COUNT_W'(blocks_free());
         return e;
      end
      case (q.func)
         FN_CLEAR: wipe_tables();
         FN_CHECK: e.image_state = slot_state(ix);
         FN_NONE: begin
            release_chain(ix);
            img_first[ix] = IMG_NON;
            e.image_state = IS_NONE;
         end
         FN_ANY: begin
            for (int i = 0; i < ni; i++)
               if (img_first[i] == IMG_EMP) begin
                  e.any_empty = 1'b1;
                  break;
               end
         end
         FN_SIZE: begin
            need = blocks_for(q.pixel_width, q.pixel_height);
            if (need == 0) e.status = ST_BAD;
            else begin
               e.blocks_needed = COUNT_W'(need);
               if (blocks_free() < need) e.status = ST_SHORT;
            end
         end
         FN_ROOM: begin
            st = 0;
            ed = int'(ni) - 1;
            e.status = ST_SHORT;
            while (st <= int'(ix) && ed >= int'(ix)) begin
               if (int'(ix) - st > ed - int'(ix)) begin
                  cr = st;
                  st++;
               end else begin
                  cr = ed;
                  ed--;
               end
               if (img_first[cr] < NBLK) release_chain(cr);
               if (blocks_free() >= q.blocks_wanted) begin
                  e.status = ST_OK;
                  break;
               end
            end
            e.image_state = slot_state(ix);
         end
         FN_STORE: begin
            need = blocks_for(q.pixel_width, q.pixel_height);
            e.image_state = slot_state(ix);
            if (need == 0) e.status = ST_BAD;
            else begin
               e.blocks_needed = COUNT_W'(need);
               avail = 0;
               for (int i = 0; i < nb; i++)
                  if (links[i] == LNK_FREE) avail++;
               avail += owned_in_range(ix, nb);
               if (avail < need) e.status = ST_SHORT;
               else begin
                  release_chain(ix);
                  img_w[ix] = q.pixel_width;
                  img_h[ix] = q.pixel_height;
                  cnt = 0;
                  prev = 0;
                  head = 0;
                  for (int i = 0; i < nb && cnt < need; i++) begin
                     if (links[i] != LNK_FREE) continue;
                     if (cnt == 0) head = i;
                     else links[prev] = i;
                     links[i] = LNK_END;
                     prev = i;
                     cnt++;
                     used_cnt++;
                  end
                  img_first[ix] = head;
                  e.image_state = IS_STORED;
                  e.first_block = BLK_IDX_W'(head);
                  e.stored_width = q.pixel_width;
                  e.stored_height = q.pixel_height;
               end
            end
         end
         FN_LOOK: begin
            e.image_state = slot_state(ix);
            if (img_first[ix] >= NBLK) e.status = ST_BAD;
            else begin
               e.first_block = BLK_IDX_W'(img_first[ix]);
               e.stored_width = PIX_W'(img_w[ix]);
               e.stored_height = PIX_W'(img_h[ix]);
            end
         end
         FN_NEXT: begin
            if (q.block_index >= nb) e.status = ST_RANGE;
            else if (links[q.block_index] == LNK_FREE) e.status = ST_BAD;
            else if (links[q.block_index] >= NBLK) e.chain_end = 1'b1;
            else e.next_block = BLK_IDX_W'(links[q.block_index]);
         end
         default: begin
            release_chain(ix);
            e.image_state = IS_EMPTY;
         end
      endcase
      e.free_blocks = COUNT_W'(blocks_free());
      return e;
   endfunction

   always @(posedge clock) begin
      rsp_t got, exp;
      if (!reset && rsp_strobe) begin
         got = '{rsp_status, rsp_image_state, rsp_first_block, rsp_stored_width,
                 rsp_stored_height, rsp_blocks_needed, rsp_next_block,
                 rsp_chain_end, rsp_free_blocks, rsp_any_empty};
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status || got.image_state !== exp.image_state
                || got.first_block !== exp.first_block
                || got.stored_width !== exp.stored_width
                || got.stored_height !== exp.stored_height
                || got.blocks_needed !== exp.blocks_needed
                || got.next_block !== exp.next_block
                || got.chain_end !== exp.chain_end
                || got.free_blocks !== exp.free_blocks
                || got.any_empty !== exp.any_empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected %p got %p", $realtime, exp, got);
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge with start held high unless a random gap lowered it
   task automatic issue(input req_t q, input bit typed, input rsp_t typed_rsp);
      rsp_t e;
      req_func <= q.func;
      req_session_id <= q.session_id;
      req_image_index <= q.image_index;
      req_pixel_width <= q.pixel_width;
      req_pixel_height <= q.pixel_height;
      req_blocks_wanted <= q.blocks_wanted;
      req_block_index <= q.block_index;
      start <= 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      e = allocate_reply(q);
      pending_rsp.push_back(typed ? typed_rsp : e);
      @(negedge clock);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] ix, input logic [SESSION_W-1:0] v);
      csr_write <= 1'b1;
      csr_index <= ix;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      case (ix)
         CSR_SESSION: cur_session = v;
         CSR_BLOCKS: blk_reg = v[BCOUNT_W-1:0];
         CSR_IMAGES: img_reg = v[ICOUNT_W-1:0];
         default: ready_reg = v[0];
      endcase
   endtask

   task automatic setup(input logic [SESSION_W-1:0] s, input int unsigned bc,
                        input int unsigned ic, input bit rdy);
      drain();
      write_reg(CSR_SESSION, s);
      write_reg(CSR_BLOCKS, SESSION_W'(bc));
      write_reg(CSR_IMAGES, SESSION_W'(ic));
      write_reg(CSR_READY, SESSION_W'(rdy));
   endtask

   function automatic req_t random_req();
      req_t q;
      int unsigned p, top;
      p = $urandom_range(99);
      if (p < 30) q.func = FN_STORE;
      else if (p < 42) q.func = FN_NEXT;
      else if (p < 52) q.func = FN_FREE;
      else if (p < 62) q.func = FN_LOOK;
      else if (p < 68) q.func = FN_ROOM;
      else if (p < 75) q.func = FN_CHECK;
      else if (p < 81) q.func = FN_NONE;
      else if (p < 86) q.func = FN_ANY;
      else if (p < 95) q.func = FN_SIZE;
      else if (p < 96) q.func = FN_CLEAR;
      else q.func = FUNC_W'($urandom_range(10, 15));
      q.session_id = ($urandom_range(99) < 95) ? cur_session
                                               : SESSION_W'({$urandom, $urandom});
      top = live_images() + 1;
      if (top > 1023) top = 1023;
      q.image_index = IMG_IDX_W'(($urandom_range(99) < 93) ? $urandom_range(0, top)
                                                           : $urandom);
      q.pixel_width = PIX_W'(($urandom_range(99) < 90) ? $urandom_range(1, 512)
                                                       : $urandom_range(0, 8191));
      q.pixel_height = PIX_W'(($urandom_range(99) < 85) ? $urandom_range(0, 64)
                                                        : $urandom_range(0, 8191));
      q.blocks_wanted = COUNT_W'(($urandom_range(99) < 90)
                                 ? $urandom_range(0, live_blocks() + 2)
                                 : $urandom_range(0, 8191));
      top = live_blocks();
      if (top > 4095) top = 4095;
      q.block_index = BLK_IDX_W'(($urandom_range(99) < 80) ? $urandom_range(0, top)
                                                           : $urandom);
      return q;
   endfunction

   task automatic add_row(input logic [FUNC_W-1:0] f, input bit good_sid,
                          input int unsigned ix, input int unsigned w,
                          input int unsigned h, input int unsigned want,
                          input int unsigned bix, input bit typed, input rsp_t e);
      row_t rw;
      rw.r = '{f, good_sid ? cur_session : ~cur_session, IMG_IDX_W'(ix), PIX_W'(w),
               PIX_W'(h), COUNT_W'(want), BLK_IDX_W'(bix)};
      rw.typed = typed;
      rw.exp = e;
      dir_rows.push_back(rw);
   endtask

   task automatic run_random(input int n);
      rsp_t z;
      z = '0;
      repeat (n) issue(random_req(), 1'b0, z);
   endtask

   initial begin
      rsp_t z;
      z = '0;
      cur_session = '0;
      blk_reg = 0;
      img_reg = 0;
      ready_reg = 0;
      wipe_tables();
      foreach (img_w[i]) begin
         img_w[i] = 0;
         img_h[i] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      setup(63'h2A5F_0C31_9E77_1B04, 16, 4, 1'b1);
      add_row(FN_CHECK, 0, 0, 1, 1, 0, 0, 1, '{ST_SESSION, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      add_row(4'd15, 1, 0, 1, 1, 0, 0, 1, z);
      add_row(FN_CHECK, 1, 0, 1, 1, 0, 0, 1, '{ST_OK, IS_EMPTY, 0, 0, 0, 0, 0, 0, 16, 0});
      add_row(FN_CHECK, 1, 4, 1, 1, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 0, 0, 0, 0, 16, 0});
      add_row(FN_ANY, 1, 0, 1, 1, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 16, 1});
      add_row(FN_SIZE, 1, 0, 0, 1, 0, 0, 1, '{ST_BAD, 0, 0, 0, 0, 0, 0, 0, 16, 0});
      add_row(FN_SIZE, 1, 0, 8191, 8191, 0, 0, 1, '{ST_BAD, 0, 0, 0, 0, 0, 0, 0, 16, 0});
      add_row(FN_SIZE, 1, 0, 4096, 4096, 0, 0, 1,
              '{ST_SHORT, 0, 0, 0, 0, 4096, 0, 0, 16, 0});
      add_row(FN_SIZE, 1, 0, 1, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 1, 0, 0, 16, 0});
      add_row(FN_STORE, 1, 0, 4096, 3, 0, 0, 0, z);
      add_row(FN_STORE, 1, 1, 2048, 4, 0, 0, 0, z);
      add_row(FN_STORE, 1, 0, 4096, 2, 0, 0, 0, z);
      add_row(FN_STORE, 1, 2, 4097, 2, 0, 0, 0, z);
      add_row(FN_STORE, 1, 2, 4096, 20, 0, 0, 0, z);
      add_row(FN_NEXT, 1, 0, 1, 1, 0, 0, 0, z);
      add_row(FN_NEXT, 1, 0, 1, 1, 0, 15, 0, z);
      add_row(FN_NEXT, 1, 0, 1, 1, 0, 16, 0, z);
      add_row(FN_NEXT, 1, 0, 1, 1, 0, 4095, 0, z);
      add_row(FN_LOOK, 1, 1, 1, 1, 0, 0, 0, z);
      add_row(FN_LOOK, 1, 3, 1, 1, 0, 0, 0, z);
      add_row(FN_NONE, 1, 1, 1, 1, 0, 0, 0, z);
      add_row(FN_LOOK, 1, 1, 1, 1, 0, 0, 0, z);
      add_row(FN_ROOM, 1, 2, 1, 1, 16, 0, 0, z);
      add_row(FN_FREE, 1, 1, 1, 1, 0, 0, 0, z);
      add_row(FN_CLEAR, 1, 0, 1, 1, 0, 0, 0, z);
      add_row(FN_ANY, 1, 0, 1, 1, 0, 0, 0, z);
      foreach (dir_rows[i]) issue(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].exp);

      setup(63'h0, 64, 16, 1'b0);
      run_random(20);
      gap_pct = 7;
      setup(63'h0, 64, 16, 1'b1);
      run_random(560);
      gap_pct = 80;
      setup({SESSION_W{1'b1}}, 4096, 1024, 1'b1);
      run_random(300);
      setup(63'h1357_9BDF_2468_ACE0, 8191, 2047, 1'b1);
      run_random(300);
      gap_pct = 0;
      setup(63'h5, 0, 0, 1'b1);
      run_random(100);
      setup(63'h3C3C_0F0F_5A5A_6969, 200, 40, 1'b1);
      run_random(250);
      drain();
      run_random(250);
      drain();
      repeat (64) @(negedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #500_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/cba_pkg.sv
hw/rtl/cba_ram.sv
hw/rtl/cba_sizer.sv
hw/rtl/chained_block_allocator.sv
dv/chained_block_allocator_tb.sv
